/* src/tpfm_pkg.sv */
// ----------------------------------------------------------------------------
// tpfm_pkg
// Shared types and constants of the thruster packet failsafe mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package tpfm_pkg;

  // item codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // frame layout
  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] STOP_BYTE  = 8'h55;

  localparam logic [1:0] POS_START = 2'd0;
  localparam logic [1:0] POS_SURGE = 2'd1;
  localparam logic [1:0] POS_SWAY  = 2'd2;
  localparam logic [1:0] POS_STOP  = 2'd3;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // command scaling: q = (m * RECIP_127) >> RECIP_SHIFT equals m / 127 for m < 2^17
  localparam logic [6:0]  CMD_FULL    = 7'd127;
  localparam logic [17:0] RECIP_127   = 18'd132105;
  localparam int          RECIP_SHIFT = 24;

  // register map
  localparam int          ADDR_W      = 4;
  localparam logic [1:0]  REG_NEUTRAL = 2'd0;
  localparam logic [1:0]  REG_DELTA   = 2'd1;
  localparam logic [1:0]  REG_TIMEOUT = 2'd2;

  localparam logic [10:0] NEUTRAL_RST = 11'd1500;
  localparam logic [9:0]  DELTA_RST   = 10'd500;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [7:0] surge_cmd;
    logic [7:0] sway_cmd;
    logic       good;
    logic       bad;
    logic       failsafe;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

endpackage

`default_nettype wire

/* src/tpfm_queue.sv */
// ----------------------------------------------------------------------------
// tpfm_queue
// Small register FIFO between the frame tracker and the width pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfm_queue #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_FULL);
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* src/tpfm_front.sv */
// ----------------------------------------------------------------------------
// tpfm_front
// Accepts bytes and ticks, tracks the frame and the timeout, classifies items.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfm_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [15:0] timeout_ms,
  input  wire logic        q_full,
  output logic             push,
  output tpfm_pkg::item_t  push_item
);

  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [7:0]  surge_pend_r, surge_pend_nxt;
  logic [7:0]  sway_pend_r, sway_pend_nxt;
  logic [7:0]  surge_cmd_r, surge_cmd_nxt;
  logic [7:0]  sway_cmd_r, sway_cmd_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        seen_r, seen_nxt;
  logic        good, bad;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    pos_nxt        = pos_r;
    start_nxt      = start_r;
    surge_pend_nxt = surge_pend_r;
    sway_pend_nxt  = sway_pend_r;
    surge_cmd_nxt  = surge_cmd_r;
    sway_cmd_nxt   = sway_cmd_r;
    elapsed_nxt    = elapsed_r;
    seen_nxt       = seen_r;
    good           = 1'b0;
    bad            = 1'b0;
    if (in_op == tpfm_pkg::OP_BYTE) begin
      unique case (pos_r)
        tpfm_pkg::POS_START: start_nxt      = in_rx_byte;
        tpfm_pkg::POS_SURGE: surge_pend_nxt = in_rx_byte;
        tpfm_pkg::POS_SWAY:  sway_pend_nxt  = in_rx_byte;
        tpfm_pkg::POS_STOP: begin
          if (start_r == tpfm_pkg::START_BYTE && in_rx_byte == tpfm_pkg::STOP_BYTE) begin
            surge_cmd_nxt = surge_pend_r;
            sway_cmd_nxt  = sway_pend_r;
            elapsed_nxt   = '0;
            seen_nxt      = 1'b1;
            good          = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        default: ;
      endcase
      pos_nxt = pos_r + 2'd1;
    end else if (elapsed_r != tpfm_pkg::ELAPSED_MAX) begin
      elapsed_nxt = elapsed_r + 16'd1;
    end
  end

  always_comb begin
    push_item.surge_cmd = surge_cmd_nxt;
    push_item.sway_cmd  = sway_cmd_nxt;
    push_item.good      = good;
    push_item.bad       = bad;
    push_item.failsafe  = !seen_nxt || (elapsed_nxt > timeout_ms);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      start_r      <= '0;
      surge_pend_r <= '0;
      sway_pend_r  <= '0;
      surge_cmd_r  <= '0;
      sway_cmd_r   <= '0;
      elapsed_r    <= '0;
      seen_r       <= 1'b0;
    end else if (push) begin
      pos_r        <= pos_nxt;
      start_r      <= start_nxt;
      surge_pend_r <= surge_pend_nxt;
      sway_pend_r  <= sway_pend_nxt;
      surge_cmd_r  <= surge_cmd_nxt;
      sway_cmd_r   <= sway_cmd_nxt;
      elapsed_r    <= elapsed_nxt;
      seen_r       <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/tpfm_back.sv */
// ----------------------------------------------------------------------------
// tpfm_back
// Three-stage width pipeline: scale, divide by 127, offset from neutral.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfm_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [10:0] neutral_width_us,
  input  wire logic [9:0]  max_delta_us,
  input  wire logic        q_empty,
  input  wire tpfm_pkg::item_t head_item,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_surge_width_us,
  output logic [11:0]      out_sway_width_us,
  output logic             out_frame_good,
  output logic             out_frame_bad,
  output logic             out_failsafe_active
);

  typedef struct packed {
    logic good;
    logic bad;
    logic failsafe;
    logic surge_neg;
    logic sway_neg;
  } flags_t;

  logic        adv;
  logic        s1_valid_r, s2_valid_r, out_valid_r;
  flags_t      s1_flags_r, s2_flags_r, s1_flags_nxt;
  logic [16:0] s1_surge_prod_r, s1_sway_prod_r;
  logic [16:0] surge_prod_nxt, sway_prod_nxt;
  logic [9:0]  s2_surge_q_r, s2_sway_q_r;
  logic [34:0] surge_recip, sway_recip;
  logic [11:0] surge_w_nxt, sway_w_nxt;
  logic [11:0] surge_w_r, sway_w_r;
  logic        good_r, bad_r, fs_r;
  logic [6:0]  surge_mag, sway_mag;

  function automatic logic [6:0] cmd_mag(input logic [7:0] cmd);
    logic [6:0] m;
    if (cmd == 8'h80) begin
      m = tpfm_pkg::CMD_FULL;
    end else if (cmd[7]) begin
      m = 7'(-cmd);
    end else begin
      m = cmd[6:0];
    end
    return m;
  endfunction

  function automatic logic [11:0] apply(input logic [10:0] neutral, input logic [9:0] q,
                                        input logic neg);
    logic [11:0] w;
    if (!neg) begin
      w = {1'b0, neutral} + {2'b0, q};
    end else if ({1'b0, q} > neutral) begin
      w = '0;
    end else begin
      w = {1'b0, neutral} - {2'b0, q};
    end
    return w;
  endfunction

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !q_empty;

  assign surge_mag      = cmd_mag(head_item.surge_cmd);
  assign sway_mag       = cmd_mag(head_item.sway_cmd);
  assign surge_prod_nxt = {10'd0, surge_mag} * {7'd0, max_delta_us};
  assign sway_prod_nxt  = {10'd0, sway_mag} * {7'd0, max_delta_us};

  always_comb begin
    s1_flags_nxt.good      = head_item.good;
    s1_flags_nxt.bad       = head_item.bad;
    s1_flags_nxt.failsafe  = head_item.failsafe;
    s1_flags_nxt.surge_neg = head_item.surge_cmd[7];
    s1_flags_nxt.sway_neg  = head_item.sway_cmd[7];
  end

  assign surge_recip = {18'd0, s1_surge_prod_r} * {17'd0, tpfm_pkg::RECIP_127};
  assign sway_recip  = {18'd0, s1_sway_prod_r} * {17'd0, tpfm_pkg::RECIP_127};

  assign surge_w_nxt = s2_flags_r.failsafe ? {1'b0, neutral_width_us}
                     : apply(neutral_width_us, s2_surge_q_r, s2_flags_r.surge_neg);
  assign sway_w_nxt  = s2_flags_r.failsafe ? {1'b0, neutral_width_us}
                     : apply(neutral_width_us, s2_sway_q_r, s2_flags_r.sway_neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= !q_empty;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flags_r      <= s1_flags_nxt;
      s1_surge_prod_r <= surge_prod_nxt;
      s1_sway_prod_r  <= sway_prod_nxt;
      s2_flags_r      <= s1_flags_r;
      s2_surge_q_r    <= surge_recip[tpfm_pkg::RECIP_SHIFT +: 10];
      s2_sway_q_r     <= sway_recip[tpfm_pkg::RECIP_SHIFT +: 10];
      surge_w_r       <= surge_w_nxt;
      sway_w_r        <= sway_w_nxt;
      good_r          <= s2_flags_r.good;
      bad_r           <= s2_flags_r.bad;
      fs_r            <= s2_flags_r.failsafe;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_surge_width_us  = surge_w_r;
  assign out_sway_width_us   = sway_w_r;
  assign out_frame_good      = good_r;
  assign out_frame_bad       = bad_r;
  assign out_failsafe_active = fs_r;

endmodule

`default_nettype wire

/* src/thruster_packet_failsafe_mapper.sv */
// ----------------------------------------------------------------------------
// thruster_packet_failsafe_mapper
// Frames serial bytes into surge/sway commands and maps them to pulse widths.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one item per handshake, either a received
// byte (in_op = byte) or a one millisecond tick (in_op = tick). Every item
// gives one result item on the out_ channel with both pulse widths and the
// frame good, frame bad and failsafe flags.
// The frame tracker takes one item per cycle unless the queue is full and
// pushes its classification into a QDEPTH-entry queue; the width pipeline
// (scale multiply, reciprocal multiply for the divide by 127, neutral offset)
// drains it; each result passes the scale, divide and offset registers.
// Throughput: one item per cycle while the queue is not full.
// A waiting result with out_ready low holds the pipeline; in_ready stays high
// until the queue fills, then drops until the receiver takes results again.
// Reset (rst_n low, synchronous) clears the frame position, the commands,
// the elapsed counter and the frame-seen flag, so outputs start in failsafe;
// registers return to neutral 1500 us, delta 500 us, timeout 1000 ms.
// Registers on APB at 0x0, 0x4, 0x8 must be written while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module thruster_packet_failsafe_mapper #(
  parameter int QDEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [11:0]                        out_surge_width_us,
  output logic [11:0]                        out_sway_width_us,
  output logic                               out_frame_good,
  output logic                               out_frame_bad,
  output logic                               out_failsafe_active,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tpfm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [10:0]     neutral_r;
  logic [9:0]      delta_r;
  logic [15:0]     timeout_r;
  logic            cfg_wr;
  logic [1:0]      reg_idx;

  logic            q_full, q_empty, push, pop;
  tpfm_pkg::item_t push_item, head_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_r <= tpfm_pkg::NEUTRAL_RST;
      delta_r   <= tpfm_pkg::DELTA_RST;
      timeout_r <= tpfm_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tpfm_pkg::REG_NEUTRAL: neutral_r <= pwdata[10:0];
        tpfm_pkg::REG_DELTA:   delta_r   <= pwdata[9:0];
        tpfm_pkg::REG_TIMEOUT: timeout_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tpfm_pkg::REG_NEUTRAL: prdata = {21'd0, neutral_r};
      tpfm_pkg::REG_DELTA:   prdata = {22'd0, delta_r};
      tpfm_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_r};
      default:               prdata = '0;
    endcase
  end

  tpfm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_rx_byte (in_rx_byte),
    .timeout_ms (timeout_r),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  tpfm_queue #(
    .WIDTH (tpfm_pkg::ITEM_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_item),
    .pop       (pop),
    .head_data (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  tpfm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .neutral_width_us    (neutral_r),
    .max_delta_us        (delta_r),
    .q_empty             (q_empty),
    .head_item           (head_item),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_surge_width_us  (out_surge_width_us),
    .out_sway_width_us   (out_sway_width_us),
    .out_frame_good      (out_frame_good),
    .out_frame_bad       (out_frame_bad),
    .out_failsafe_active (out_failsafe_active)
  );

  a_good_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_good && out_frame_bad))
    else $error("frame good and bad on the same item");

  a_good_not_failsafe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_good) |-> !out_failsafe_active)
    else $error("failsafe right after a good frame");

  a_failsafe_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_failsafe_active) |-> (out_surge_width_us == out_sway_width_us))
    else $error("failsafe widths differ");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !pop) |=> !(in_valid && in_ready && $past(q_full) && q_full))
    else $error("item accepted into a full queue");

endmodule

`default_nettype wire

/* tb/thruster_packet_failsafe_mapper_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thruster_packet_failsafe_mapper_tb
// Drives byte and tick items through the mapper and checks every result
// against a typed directed row or else an in-bench model of the frame
// tracker, elapsed-time failsafe and pulse width scaling. A short table of
// directed items comes first, then random phases over several register
// settings, with random idling on both channels and one long receiver stall.
// ----------------------------------------------------------------------------
module thruster_packet_failsafe_mapper_tb;

  localparam int PHASE_ITEMS   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 40;
  localparam int STALL_LIMIT   = 1000;

  typedef struct packed {
    logic [11:0] surge;
    logic [11:0] sway;
    logic        good;
    logic        bad;
    logic        failsafe;
  } pulse_result_t;

  typedef struct packed {
    logic          op;
    logic [7:0]    data;
    logic          typed;
    pulse_result_t result;
  } stim_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_op;
  logic [7:0]                  in_rx_byte;
  logic                        out_valid;
  logic                        out_ready;
  logic [11:0]                 out_surge_width_us;
  logic [11:0]                 out_sway_width_us;
  logic                        out_frame_good;
  logic                        out_frame_bad;
  logic                        out_failsafe_active;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [tpfm_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  // model state
  logic [10:0] neutral_us     = tpfm_pkg::NEUTRAL_RST;
  logic [9:0]  delta_us       = tpfm_pkg::DELTA_RST;
  logic [15:0] timeout_ms_cfg = tpfm_pkg::TIMEOUT_RST;
  logic [1:0]  frame_pos      = tpfm_pkg::POS_START;
  logic [7:0]  start_held     = '0;
  logic [7:0]  surge_pend     = '0;
  logic [7:0]  sway_pend      = '0;
  logic [7:0]  surge_cmd      = '0;
  logic [7:0]  sway_cmd       = '0;
  logic [15:0] elapsed        = '0;
  logic        frame_seen     = 1'b0;

  pulse_result_t pending_widths [$];
  pulse_result_t predicted;
  pulse_result_t want;
  logic          row_typed;
  pulse_result_t row_expect;

  int          errors        = 0;
  int          stall_cycles  = 0;
  int          items_sent    = 0;
  int          send_idle_pct = 12;
  int          recv_idle_pct = 62;
  logic [1:0]  gen_pos       = tpfm_pkg::POS_START;
  logic        hold_start    = 1'b0;
  logic        hold_done     = 1'b0;
  logic        paused_once   = 1'b0;

  stim_row_t   directed [24];
  int unsigned phase_neutral [6] = '{1000, 2000, 0, 2047, 1500, 1234};
  int unsigned phase_delta   [6] = '{1000, 0, 1023, 1023, 500, 777};
  int unsigned phase_timeout [6] = '{3, 0, 1, 10, 20, 65535};

  thruster_packet_failsafe_mapper u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_surge_width_us  (out_surge_width_us),
    .out_sway_width_us   (out_sway_width_us),
    .out_frame_good      (out_frame_good),
    .out_frame_bad       (out_frame_bad),
    .out_failsafe_active (out_failsafe_active),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [11:0] pulse_width(logic [7:0] cmd);
    int v;
    int w;
    v = int'($signed(cmd));
    if (v > int'(tpfm_pkg::CMD_FULL)) v = int'(tpfm_pkg::CMD_FULL);
    if (v < -int'(tpfm_pkg::CMD_FULL)) v = -int'(tpfm_pkg::CMD_FULL);
    w = int'(neutral_us) + (v * int'(delta_us)) / int'(tpfm_pkg::CMD_FULL);
    if (w < 0) w = 0;
    if (w > 4095) w = 4095;
    return 12'(w);
  endfunction

  function automatic pulse_result_t advance_frame(logic op, logic [7:0] b);
    pulse_result_t r;
    r = '0;
    if (op == tpfm_pkg::OP_BYTE) begin
      case (frame_pos)
        tpfm_pkg::POS_START: start_held = b;
        tpfm_pkg::POS_SURGE: surge_pend = b;
        tpfm_pkg::POS_SWAY:  sway_pend  = b;
        default: begin
          if (start_held == tpfm_pkg::START_BYTE && b == tpfm_pkg::STOP_BYTE) begin
            surge_cmd  = surge_pend;
            sway_cmd   = sway_pend;
            elapsed    = '0;
            frame_seen = 1'b1;
            r.good     = 1'b1;
          end else begin
            r.bad = 1'b1;
          end
        end
      endcase
      frame_pos = frame_pos + 2'd1;
    end else if (elapsed != tpfm_pkg::ELAPSED_MAX) begin
      elapsed = elapsed + 16'd1;
    end
    r.failsafe = !frame_seen || (elapsed > timeout_ms_cfg);
    if (r.failsafe) begin
      r.surge = {1'b0, neutral_us};
      r.sway  = {1'b0, neutral_us};
    end else begin
      r.surge = pulse_width(surge_cmd);
      r.sway  = pulse_width(sway_cmd);
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_cmd();
    logic [7:0] corner_cmds [5] = '{8'h80, 8'h81, 8'h7F, 8'h00, 8'hFF};
    if ($urandom_range(0, 99) < 25) return corner_cmds[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic check_field(input string what, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  // scoreboard: push on input handshake, compare on output handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = advance_frame(in_op, in_rx_byte);
        pending_widths.push_back(row_typed ? row_expect : predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_widths.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual surge %0d",
                   $time, out_surge_width_us);
          errors++;
        end else begin
          want = pending_widths.pop_front();
          check_field("surge width", want.surge, out_surge_width_us);
          check_field("sway width", want.sway, out_sway_width_us);
          check_field("frame good", want.good, out_frame_good);
          check_field("frame bad", want.bad, out_frame_bad);
          check_field("failsafe", want.failsafe, out_failsafe_active);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // receiver, with one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_done) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_op      = op;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (op == tpfm_pkg::OP_BYTE) gen_pos = gen_pos + 2'd1;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(tpfm_pkg::OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // four bytes, with the odd tick slipped in before any of them
  task automatic send_framed(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    logic [7:0] bytes [4];
    bytes = '{b0, b1, b2, b3};
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 99) < 15) send_ticks($urandom_range(1, 2));
      send_item(tpfm_pkg::OP_BYTE, bytes[i]);
    end
  endtask

  task automatic send_good_frame();
    while (gen_pos != tpfm_pkg::POS_START) begin
      send_item(tpfm_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
    end
    send_framed(tpfm_pkg::START_BYTE, pick_cmd(), pick_cmd(), tpfm_pkg::STOP_BYTE);
  endtask

  task automatic send_random_unit();
    int         kind;
    logic [7:0] first;
    logic [7:0] last;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      send_good_frame();
    end else if (kind < 75) begin
      if (timeout_ms_cfg <= 40) send_ticks($urandom_range(1, int'(timeout_ms_cfg) + 3));
      else send_ticks($urandom_range(1, 8));
    end else if (kind < 92) begin
      first = $urandom_range(0, 1) ? tpfm_pkg::START_BYTE : 8'($urandom_range(0, 255));
      last  = $urandom_range(0, 1) ? tpfm_pkg::STOP_BYTE : 8'($urandom_range(0, 255));
      send_framed(first, pick_cmd(), pick_cmd(), last);
    end else begin
      send_item(tpfm_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_widths.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] index, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = tpfm_pkg::ADDR_W'({index, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      tpfm_pkg::REG_NEUTRAL: neutral_us     = value[10:0];
      tpfm_pkg::REG_DELTA:   delta_us       = value[9:0];
      tpfm_pkg::REG_TIMEOUT: timeout_ms_cfg = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = tpfm_pkg::OP_BYTE;
    in_rx_byte = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    row_typed  = 1'b0;
    row_expect = '0;
    directed = '{
      '{tpfm_pkg::OP_TICK, 8'h00, 1'b1, '{12'd1500, 12'd1500, 1'b0, 1'b0, 1'b1}},
      '{tpfm_pkg::OP_BYTE, 8'hAA, 1'b1, '{12'd1500, 12'd1500, 1'b0, 1'b0, 1'b1}},
      '{tpfm_pkg::OP_BYTE, 8'h7F, 1'b1, '{12'd1500, 12'd1500, 1'b0, 1'b0, 1'b1}},
      '{tpfm_pkg::OP_BYTE, 8'h80, 1'b1, '{12'd1500, 12'd1500, 1'b0, 1'b0, 1'b1}},
      '{tpfm_pkg::OP_BYTE, 8'h55, 1'b1, '{12'd2000, 12'd1000, 1'b1, 1'b0, 1'b0}},
      '{tpfm_pkg::OP_TICK, 8'hFF, 1'b1, '{12'd2000, 12'd1000, 1'b0, 1'b0, 1'b0}},
      '{tpfm_pkg::OP_BYTE, 8'h00, 1'b1, '{12'd2000, 12'd1000, 1'b0, 1'b0, 1'b0}},
      '{tpfm_pkg::OP_BYTE, 8'hFF, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'h01, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'h55, 1'b1, '{12'd2000, 12'd1000, 1'b0, 1'b1, 1'b0}},
      '{tpfm_pkg::OP_BYTE, 8'hAA, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'h81, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'h7E, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'hAA, 1'b1, '{12'd2000, 12'd1000, 1'b0, 1'b1, 1'b0}},
      '{tpfm_pkg::OP_BYTE, 8'hAA, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'hFF, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'h01, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'h55, 1'b0, '0},
      '{tpfm_pkg::OP_TICK, 8'h5A, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'hAA, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'h00, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'h00, 1'b0, '0},
      '{tpfm_pkg::OP_BYTE, 8'h55, 1'b1, '{12'd1500, 12'd1500, 1'b1, 1'b0, 1'b0}},
      '{tpfm_pkg::OP_TICK, 8'hFF, 1'b1, '{12'd1500, 12'd1500, 1'b0, 1'b0, 1'b0}}
    };

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      row_typed  = directed[i].typed;
      row_expect = directed[i].result;
      send_item(directed[i].op, directed[i].data);
    end
    row_typed = 1'b0;

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      cfg_write(tpfm_pkg::REG_NEUTRAL, phase_neutral[p]);
      cfg_write(tpfm_pkg::REG_DELTA, phase_delta[p]);
      cfg_write(tpfm_pkg::REG_TIMEOUT, phase_timeout[p]);
      if (p < 2) begin
        send_idle_pct = 12;
        recv_idle_pct = 62;
      end else if (p < 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        if (p == 1 && !paused_once && items_sent >= 150) begin
          wait_drained();
          paused_once = 1'b1;
        end
        if (p == 4 && !hold_start && items_sent >= 100) hold_start = 1'b1;
        send_random_unit();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/tpfm_pkg.sv
src/tpfm_queue.sv
src/tpfm_front.sv
src/tpfm_back.sv
src/thruster_packet_failsafe_mapper.sv
tb/thruster_packet_failsafe_mapper_tb.sv
